// ===== rtl/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescape block.
package jsu_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    // One group holds every result word caused by one source byte.
    typedef struct packed {
        logic [1:0]      cnt_m1;
        logic [1:0]      kind;
        logic [3:0][7:0] bytes;
    } grp_t;

endpackage

// ===== rtl/jsu_if.sv =====
// Stream interfaces for source words and result words.
interface jsu_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jsu_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ===== rtl/jsu_front.sv =====
// Front end: parses source bytes and produces at most one result group per byte.
module jsu_front (
    input  logic           clk,
    input  logic           rst_n,
    jsu_text_if.sink       text,
    input  logic           full,
    output logic           wr_en,
    output jsu_pkg::grp_t  wr_data
);
    import jsu_pkg::*;

    typedef enum logic [6:0] {
        MODE_IDLE = 7'b0000001,
        MODE_STR  = 7'b0000010,
        MODE_ESC  = 7'b0000100,
        MODE_HEX1 = 7'b0001000,
        MODE_BS2  = 7'b0010000,
        MODE_U2   = 7'b0100000,
        MODE_HEX2 = 7'b1000000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [11:0] hex_acc_reg, hex_acc_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [9:0]  hs_reg, hs_next;
    logic [1:0]  rem_reg, rem_next;
    logic [1:0]  len_reg, len_next;
    logic [3:0]  lead_reg, lead_next;

    logic        accept;
    logic        push;
    logic        fail;
    logic        go_idle;
    logic        second;
    logic        bad_first;
    logic [4:0]  hv;
    logic [15:0] acc16;
    logic [9:0]  ctest;
    logic [7:0]  b;
    grp_t        grp;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
            default:       r = '0;
        endcase
        return r;
    endfunction

    function automatic grp_t encode_cp(input logic [20:0] cp);
        grp_t g;
        g      = '0;
        g.kind = KIND_DATA;
        if (cp <= 21'h00007F) begin
            g.cnt_m1   = 2'd0;
            g.bytes[0] = cp[7:0];
        end
        else if (cp <= 21'h0007FF) begin
            g.cnt_m1   = 2'd1;
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'h00FFFF) begin
            g.cnt_m1   = 2'd2;
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            g.cnt_m1   = 2'd3;
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

    function automatic grp_t data_byte(input logic [7:0] d);
        grp_t g;
        g          = '0;
        g.kind     = KIND_DATA;
        g.bytes[0] = d;
        return g;
    endfunction

    assign text.ready = !full;
    assign accept     = text.valid && !full;
    assign wr_en      = accept && push;
    assign wr_data    = grp;

    assign b      = text.in_byte;
    assign hv     = hex_value(b);
    assign acc16  = {hex_acc_reg, hv[3:0]};
    assign ctest  = {lead_reg, b[5:0]};
    assign second = (mode_reg == MODE_HEX2);

    always_comb
    begin
        bad_first = 1'b0;
        if (len_reg == 2'd2)
        begin
            bad_first = (ctest < 10'h020) || (ctest >= 10'h360 && ctest <= 10'h37F);
        end
        else if (len_reg == 2'd3)
        begin
            bad_first = (ctest < 10'h010) || (ctest > 10'h10F);
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        hex_acc_next = hex_acc_reg;
        hex_cnt_next = hex_cnt_reg;
        hs_next      = hs_reg;
        rem_next     = rem_reg;
        len_next     = len_reg;
        lead_next    = lead_reg;
        push         = 1'b0;
        grp          = '0;
        fail         = 1'b0;
        go_idle      = 1'b0;

        if (text.end_of_text)
        begin
            if (mode_reg != MODE_IDLE)
            begin
                fail = 1'b1;
            end
            go_idle = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if (b == CHAR_QUOTE)
                    begin
                        mode_next = MODE_STR;
                    end
                end
                MODE_STR:
                begin
                    if (rem_reg != 2'd0)
                    begin
                        if (b[7:6] != 2'b10)
                        begin
                            fail = 1'b1;
                        end
                        else if (rem_reg == len_reg && bad_first)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            push     = 1'b1;
                            grp      = data_byte(b);
                            rem_next = rem_reg - 2'd1;
                        end
                    end
                    else if (b == CHAR_QUOTE)
                    begin
                        push     = 1'b1;
                        grp.kind = KIND_COMPLETE;
                        go_idle  = 1'b1;
                    end
                    else if (b < CTRL_LIMIT)
                    begin
                        fail = 1'b1;
                    end
                    else if (b == CHAR_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else if (b < ASCII_LIMIT)
                    begin
                        push = 1'b1;
                        grp  = data_byte(b);
                    end
                    else if (b >= 8'hC2 && b <= 8'hF4)
                    begin
                        push      = 1'b1;
                        grp       = data_byte(b);
                        lead_next = b[3:0];
                        if (b <= 8'hDF)
                        begin
                            len_next = 2'd1;
                            rem_next = 2'd1;
                        end
                        else if (b <= 8'hEF)
                        begin
                            len_next = 2'd2;
                            rem_next = 2'd2;
                        end
                        else
                        begin
                            len_next = 2'd3;
                            rem_next = 2'd3;
                        end
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    mode_next = MODE_STR;
                    push      = 1'b1;
                    unique case (b)
                        CHAR_QUOTE:  grp = data_byte(CHAR_QUOTE);
                        CHAR_BSLASH: grp = data_byte(CHAR_BSLASH);
                        CHAR_SLASH:  grp = data_byte(CHAR_SLASH);
                        CHAR_B:      grp = data_byte(8'h08);
                        CHAR_F:      grp = data_byte(8'h0C);
                        CHAR_N:      grp = data_byte(8'h0A);
                        CHAR_R:      grp = data_byte(8'h0D);
                        CHAR_T:      grp = data_byte(8'h09);
                        CHAR_U:
                        begin
                            push         = 1'b0;
                            mode_next    = MODE_HEX1;
                            hex_acc_next = '0;
                            hex_cnt_next = '0;
                        end
                        default:
                        begin
                            push = 1'b0;
                            fail = 1'b1;
                        end
                    endcase
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    if (!hv[4])
                    begin
                        fail = 1'b1;
                    end
                    else if (hex_cnt_reg != 2'd3)
                    begin
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                        hex_acc_next = acc16[11:0];
                        if (!second && hex_cnt_reg == 2'd1 && acc16 >= 16'h00DC
                            && acc16 <= 16'h00DF)
                        begin
                            fail = 1'b1;
                        end
                        else if (second && hex_cnt_reg == 2'd0 && acc16 != 16'h000D)
                        begin
                            fail = 1'b1;
                        end
                        else if (second && hex_cnt_reg == 2'd1 && acc16 < 16'h00DC)
                        begin
                            fail = 1'b1;
                        end
                    end
                    else
                    begin
                        hex_cnt_next = '0;
                        hex_acc_next = '0;
                        if (!second)
                        begin
                            if (acc16 >= 16'hD800 && acc16 <= 16'hDBFF)
                            begin
                                hs_next   = acc16[9:0];
                                mode_next = MODE_BS2;
                            end
                            else if (acc16 >= 16'hDC00 && acc16 <= 16'hDFFF)
                            begin
                                fail = 1'b1;
                            end
                            else
                            begin
                                push      = 1'b1;
                                grp       = encode_cp({5'd0, acc16});
                                mode_next = MODE_STR;
                            end
                        end
                        else
                        begin
                            if (acc16 < 16'hDC00 || acc16 > 16'hDFFF)
                            begin
                                fail = 1'b1;
                            end
                            else
                            begin
                                push      = 1'b1;
                                grp       = encode_cp({{1'b0, hs_reg} + 11'h040, acc16[9:0]});
                                hs_next   = '0;
                                mode_next = MODE_STR;
                            end
                        end
                    end
                end
                MODE_BS2:
                begin
                    if (b == CHAR_BSLASH)
                    begin
                        mode_next = MODE_U2;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                MODE_U2:
                begin
                    if (b == CHAR_U)
                    begin
                        mode_next    = MODE_HEX2;
                        hex_acc_next = '0;
                        hex_cnt_next = '0;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase
        end

        if (fail)
        begin
            push     = 1'b1;
            grp      = '0;
            grp.kind = KIND_ERROR;
            go_idle  = 1'b1;
        end
        if (go_idle)
        begin
            mode_next    = MODE_IDLE;
            hex_acc_next = '0;
            hex_cnt_next = '0;
            hs_next      = '0;
            rem_next     = '0;
            len_next     = '0;
            lead_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            hex_acc_reg <= '0;
            hex_cnt_reg <= '0;
            hs_reg      <= '0;
            rem_reg     <= '0;
            len_reg     <= '0;
            lead_reg    <= '0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            hex_acc_reg <= hex_acc_next;
            hex_cnt_reg <= hex_cnt_next;
            hs_reg      <= hs_next;
            rem_reg     <= rem_next;
            len_reg     <= len_next;
            lead_reg    <= lead_next;
        end
    end

endmodule

// ===== rtl/jsu_queue.sv =====
// Short queue of result groups between the parser and the serializer.
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  jsu_pkg::grp_t  wr_data,
    output logic           full,
    output logic           deq_valid,
    output jsu_pkg::grp_t  deq_data,
    input  logic           pop
);
    import jsu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    grp_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign deq_valid = (cnt_reg != '0);
    assign deq_data  = mem[rd_ptr_reg];
    assign do_pop    = pop && deq_valid;

    always_comb
    begin
        case ({wr_en, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: sends the words of each queued group, one per cycle while decoded is ready, from an output register.
module jsu_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           deq_valid,
    input  jsu_pkg::grp_t  deq_data,
    output logic           pop,
    jsu_result_if.source   decoded
);
    import jsu_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] kind_reg;
    logic       last_reg;
    logic       load;
    logic       final_word;

    assign load       = !valid_reg || decoded.ready;
    assign final_word = (idx_reg == deq_data.cnt_m1);
    assign pop        = load && deq_valid && final_word;

    assign decoded.valid    = valid_reg;
    assign decoded.out_byte = byte_reg;
    assign decoded.kind     = kind_reg;
    assign decoded.last     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= deq_valid;
            if (deq_valid)
            begin
                idx_reg <= final_word ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && deq_valid)
        begin
            byte_reg <= deq_data.bytes[idx_reg];
            kind_reg <= deq_data.kind;
            last_reg <= final_word;
        end
    end

endmodule

// ===== rtl/json_string_unescape.sv =====
// Top level of the streaming JSON string unescape block.
//
// The text channel (in_byte, end_of_text) takes one source word per cycle if not full.
// The decoded channel gives result words: out_byte, kind (data, string complete,
// error) and last, which marks the final word caused by one source word.
// A source word is parsed in the cycle it is accepted and its results go into a
// small queue of groups; the first result word of a source word is loaded from
// the queue into the output register and then presented on decoded.
// The serializer sends one word per cycle while decoded is ready, so a \u escape
// that makes four words keeps the output busy as the parser keeps taking
// source words until the queue fills. While decoded is ready, the sustained rate
// is one source word per cycle, set by the single parse step and one-word output.
// When decoded stalls, the output register holds its word, the queue fills and
// then text.ready drops; nothing is lost or repeated.
// Reset returns the parser to waiting for an opening quote and empties the
// queue and the output register.
module json_string_unescape #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    jsu_text_if.sink      text,
    jsu_result_if.source  decoded
);
    import jsu_pkg::*;

    logic wr_en;
    grp_t wr_data;
    logic full;
    logic deq_valid;
    grp_t deq_data;
    logic pop;

    jsu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text),
        .full    (full),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .full      (full),
        .deq_valid (deq_valid),
        .deq_data  (deq_data),
        .pop       (pop)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .deq_valid (deq_valid),
        .deq_data  (deq_data),
        .pop       (pop),
        .decoded   (decoded)
    );

endmodule

// ===== rtl/json_string_unescape_chk.sv =====
// Port-level assertions for the JSON string unescape block, with their bind.
module json_string_unescape_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] kind,
    input logic       last
);
    import jsu_pkg::*;

    // A completion or error word always stands alone for its source word.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> last)
        else $error("status word without last");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> out_byte == 8'h00)
        else $error("status word with nonzero byte");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == KIND_DATA || kind == KIND_COMPLETE || kind == KIND_ERROR)
        else $error("unused kind code");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
            && $stable(last))
        else $error("stalled word changed");

endmodule

bind json_string_unescape json_string_unescape_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (decoded.valid),
    .out_ready (decoded.ready),
    .out_byte  (decoded.out_byte),
    .kind      (decoded.kind),
    .last      (decoded.last)
);
